// ===== rtl/core/pmbm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmbm_pkg
// Shared types, codes and defaults for the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package pmbm_pkg;

    localparam int DEF_MAX_STATES = 256;

    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_BUILD   = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_BUILD   = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [1:0] status;
        logic       matched;
    } t_result;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_PAT_RD, S_PAT_EV, S_R_RD, S_R_EV, S_Q_CHK, S_Q_EV,
        S_F_EV, S_C_RD, S_C_EV, S_WK_RD, S_WK_EV, S_WK_FL, S_A_EV, S_T_AC,
        S_TX_END, S_B_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_PAT_RD, OP_PAT_EV, OP_ROOT_RD, OP_ROOT_EV,
        OP_Q_RD, OP_Q_EV, OP_F_EV, OP_C_RD, OP_C_EV, OP_WK_RD, OP_WK_EV,
        OP_WK_FL, OP_A_EV, OP_T_AC, OP_TX_END, OP_B_END
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       built;
        logic       edge_zero;
        logic       b_last;
        logic       queue_empty;
        logic       sweep_done;
        logic       walk_more;
        logic       walk_reset;
    } t_dp_status;

endpackage

// ===== rtl/core/pmbm_ram.sv =====
// ----------------------------------------------------------------------------
// pmbm_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pmbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pmbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmbm_ctrl
// Sequencer for insert, link build, text walk and clear sweep.
// ----------------------------------------------------------------------------
module pmbm_ctrl
    import pmbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_mode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_status.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    case (i_mode)
                        MODE_PATTERN: n_state = S_PAT_RD;
                        MODE_BUILD:   n_state = S_R_RD;
                        MODE_TEXT:    n_state = i_status.built ? S_WK_RD : S_TX_END;
                        default:      n_state = S_CLR;
                    endcase
                end
            end
            S_PAT_RD: begin
                o_cmd.op = OP_PAT_RD;
                n_state  = S_PAT_EV;
            end
            S_PAT_EV: begin
                o_cmd.op = OP_PAT_EV;
                n_state  = S_IDLE;
            end
            S_R_RD: begin
                o_cmd.op = OP_ROOT_RD;
                n_state  = S_R_EV;
            end
            S_R_EV: begin
                o_cmd.op = OP_ROOT_EV;
                n_state  = i_status.b_last ? S_Q_CHK : S_R_RD;
            end
            S_Q_CHK: begin
                if (i_status.queue_empty) begin
                    n_state = S_B_END;
                end else begin
                    o_cmd.op = OP_Q_RD;
                    n_state  = S_Q_EV;
                end
            end
            S_Q_EV: begin
                o_cmd.op = OP_Q_EV;
                n_state  = S_F_EV;
            end
            S_F_EV: begin
                o_cmd.op = OP_F_EV;
                n_state  = S_C_RD;
            end
            S_C_RD: begin
                o_cmd.op = OP_C_RD;
                n_state  = S_C_EV;
            end
            S_C_EV: begin
                o_cmd.op = OP_C_EV;
                if (!i_status.edge_zero) n_state = S_WK_RD;
                else if (i_status.b_last) n_state = S_Q_CHK;
                else n_state = S_C_RD;
            end
            S_WK_RD: begin
                o_cmd.op = OP_WK_RD;
                n_state  = S_WK_EV;
            end
            S_WK_EV: begin
                o_cmd.op = OP_WK_EV;
                if (i_status.walk_more) n_state = S_WK_FL;
                else if (i_status.walk_reset) n_state = S_WK_RD;
                else if (i_status.mode == MODE_BUILD) n_state = S_A_EV;
                else n_state = S_T_AC;
            end
            S_WK_FL: begin
                o_cmd.op = OP_WK_FL;
                n_state  = S_WK_RD;
            end
            S_A_EV: begin
                o_cmd.op = OP_A_EV;
                n_state  = i_status.b_last ? S_Q_CHK : S_C_RD;
            end
            S_T_AC: begin
                o_cmd.op = OP_T_AC;
                n_state  = S_IDLE;
            end
            S_TX_END: begin
                o_cmd.op = OP_TX_END;
                n_state  = S_IDLE;
            end
            S_B_END: begin
                o_cmd.op = OP_B_END;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/pmbm_dp.sv =====
// ----------------------------------------------------------------------------
// pmbm_dp
// Datapath: goto table, failure links, accept marks, node queue and counters.
// ----------------------------------------------------------------------------
module pmbm_dp
    import pmbm_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_result_valid,
    output t_result    o_result
);

    localparam int SW      = $clog2(MAX_STATES);
    localparam int GA      = SW + 8;
    localparam int G_DEPTH = MAX_STATES * 256;

    logic [1:0]    r_mode;
    logic [7:0]    r_byte;
    logic          r_last;
    logic [SW:0]   r_nc;
    logic [SW-1:0] r_ins;
    logic [SW-1:0] r_ms;
    logic          r_found;
    logic          r_ovf;
    logic          r_built;
    logic [SW:0]   r_head;
    logic [SW:0]   r_tail;
    logic [7:0]    r_b;
    logic [SW-1:0] r_t;
    logic [SW-1:0] r_ft;
    logic [SW-1:0] r_s;
    logic [SW-1:0] r_node;
    logic [SW:0]   r_guard;
    logic [GA-1:0] r_sweep;
    logic          r_res_valid;
    t_result       r_res;

    logic          g_we;
    logic [GA-1:0] g_waddr, g_raddr;
    logic [SW-1:0] g_wdata, g_rdata;
    logic          f_we;
    logic [SW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
    logic          a_we;
    logic [SW-1:0] a_waddr, a_raddr;
    logic          a_wdata, a_rdata;
    logic          q_we;
    logic [SW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    logic          edge_zero, nc_room, tail_room, walk_more, walk_reset, p_ovf;
    logic [SW-1:0] p_ins;
    logic [7:0]    wb;
    logic          found_n;

    assign edge_zero  = (g_rdata == '0);
    assign nc_room    = (r_nc < (SW+1)'(MAX_STATES));
    assign tail_room  = (r_tail < (SW+1)'(MAX_STATES));
    assign walk_more  = (r_node != '0) && edge_zero && (r_guard < (SW+1)'(MAX_STATES));
    assign walk_reset = (r_node != '0) && edge_zero && !(r_guard < (SW+1)'(MAX_STATES));
    assign p_ovf      = r_ovf | (edge_zero & ~nc_room);
    assign p_ins      = !edge_zero ? g_rdata : (nc_room ? r_nc[SW-1:0] : r_ins);
    assign wb         = (r_mode == MODE_BUILD) ? r_b : r_byte;
    assign found_n    = r_found | a_rdata;

    always_comb begin
        g_we    = 1'b0;
        g_waddr = {r_ins, r_byte};
        g_wdata = r_nc[SW-1:0];
        g_raddr = {r_ins, r_byte};
        f_we    = 1'b0;
        f_waddr = r_s;
        f_wdata = g_rdata;
        f_raddr = r_node;
        a_we    = 1'b0;
        a_waddr = r_s;
        a_wdata = 1'b1;
        a_raddr = g_rdata;
        q_we    = 1'b0;
        q_waddr = r_tail[SW-1:0];
        q_wdata = g_rdata;
        q_raddr = r_head[SW-1:0];
        case (i_cmd.op)
            OP_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_sweep;
                g_wdata = '0;
                if (r_sweep < GA'(MAX_STATES)) begin
                    f_we    = 1'b1;
                    f_waddr = r_sweep[SW-1:0];
                    f_wdata = '0;
                    a_we    = 1'b1;
                    a_waddr = r_sweep[SW-1:0];
                    a_wdata = 1'b0;
                end
            end
            OP_PAT_EV: begin
                g_we = edge_zero & nc_room;
                if (r_last && !p_ovf) begin
                    a_we    = 1'b1;
                    a_waddr = p_ins;
                end
            end
            OP_ROOT_RD: g_raddr = {SW'(0), r_b};
            OP_ROOT_EV: begin
                if (!edge_zero && tail_room) begin
                    f_we    = 1'b1;
                    f_waddr = g_rdata;
                    f_wdata = '0;
                    q_we    = 1'b1;
                end
            end
            OP_Q_EV: f_raddr = q_rdata;
            OP_C_RD: g_raddr = {r_t, r_b};
            OP_C_EV: q_we = !edge_zero && tail_room;
            OP_WK_RD: g_raddr = {r_node, wb};
            OP_WK_EV: begin
                f_we = !walk_more && !walk_reset && (r_mode == MODE_BUILD);
            end
            OP_A_EV: a_we = a_rdata;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_PAT_EV, OP_T_AC, OP_TX_END: r_res_valid <= r_last;
                OP_B_END:                      r_res_valid <= 1'b1;
                default:                       r_res_valid <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_CLEAR;
            r_byte      <= '0;
            r_last      <= 1'b0;
            r_nc        <= (SW+1)'(1);
            r_ins       <= '0;
            r_ms        <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_built     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_b         <= '0;
            r_t         <= '0;
            r_ft        <= '0;
            r_s         <= '0;
            r_node      <= '0;
            r_guard     <= '0;
            r_sweep     <= '0;
            r_res       <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLR: r_sweep <= r_sweep + GA'(1);
                OP_LOAD: begin
                    r_mode  <= i_item.mode;
                    r_byte  <= i_item.byte_value;
                    r_last  <= i_item.last_item;
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_b     <= '0;
                    r_node  <= r_ms;
                    r_guard <= '0;
                    if (i_item.mode == MODE_CLEAR) begin
                        r_nc    <= (SW+1)'(1);
                        r_ins   <= '0;
                        r_ms    <= '0;
                        r_found <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_built <= 1'b0;
                        r_sweep <= '0;
                    end
                end
                OP_PAT_EV: begin
                    r_built <= 1'b0;
                    r_ovf   <= p_ovf;
                    r_ins   <= r_last ? '0 : p_ins;
                    if (edge_zero && nc_room) r_nc <= r_nc + (SW+1)'(1);
                    if (r_last) begin
                        r_res.result_kind <= KIND_PATTERN;
                        r_res.status      <= p_ovf ? STATUS_FULL : STATUS_OK;
                        r_res.matched     <= 1'b0;
                    end
                end
                OP_ROOT_EV: begin
                    if (!edge_zero && tail_room) r_tail <= r_tail + (SW+1)'(1);
                    r_b <= r_b + 8'd1;
                end
                OP_Q_RD: r_head <= r_head + (SW+1)'(1);
                OP_Q_EV: begin
                    r_t <= q_rdata;
                    r_b <= '0;
                end
                OP_F_EV: r_ft <= f_rdata;
                OP_C_EV: begin
                    if (edge_zero) begin
                        r_b <= r_b + 8'd1;
                    end else begin
                        r_s     <= g_rdata;
                        r_node  <= r_ft;
                        r_guard <= '0;
                        if (tail_room) r_tail <= r_tail + (SW+1)'(1);
                    end
                end
                OP_WK_EV: begin
                    if (walk_more) begin
                        r_guard <= r_guard + (SW+1)'(1);
                    end else if (walk_reset) begin
                        r_node <= '0;
                    end else if (r_mode != MODE_BUILD) begin
                        r_ms <= g_rdata;
                    end
                end
                OP_WK_FL: r_node <= f_rdata;
                OP_A_EV: r_b <= r_b + 8'd1;
                OP_T_AC: begin
                    if (r_last) begin
                        r_res.result_kind <= KIND_TEXT;
                        r_res.status      <= r_ovf ? STATUS_FULL : STATUS_OK;
                        r_res.matched     <= found_n;
                        r_ms              <= '0;
                        r_found           <= 1'b0;
                    end else begin
                        r_found <= found_n;
                    end
                end
                OP_TX_END: begin
                    if (r_last) begin
                        r_res.result_kind <= KIND_TEXT;
                        r_res.status      <= STATUS_NOT_BUILT;
                        r_res.matched     <= 1'b0;
                        r_ms              <= '0;
                        r_found           <= 1'b0;
                    end
                end
                OP_B_END: begin
                    r_built           <= 1'b1;
                    r_ms              <= '0;
                    r_found           <= 1'b0;
                    r_res.result_kind <= KIND_BUILD;
                    r_res.status      <= r_ovf ? STATUS_FULL : STATUS_OK;
                    r_res.matched     <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    pmbm_ram #(.WIDTH(SW), .DEPTH(G_DEPTH)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    pmbm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    pmbm_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_accept (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    pmbm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    assign o_status.mode        = r_mode;
    assign o_status.built       = r_built;
    assign o_status.edge_zero   = edge_zero;
    assign o_status.b_last      = (r_b == 8'hFF);
    assign o_status.queue_empty = (r_head == r_tail);
    assign o_status.sweep_done  = (r_sweep == GA'(G_DEPTH - 1));
    assign o_status.walk_more   = walk_more;
    assign o_status.walk_reset  = walk_reset;

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    a_nc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nc <= (SW+1)'(MAX_STATES) && r_nc != '0)
        else $error("node count out of range");

    a_ins_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ins} < r_nc)
        else $error("insert node beyond allocated nodes");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_not_built_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.status == STATUS_NOT_BUILT) |-> r_res.result_kind == KIND_TEXT)
        else $error("not-built status on non-text result");

endmodule

// ===== rtl/core/multi_pattern_byte_matcher_core.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_core
// Multi-pattern byte matcher built as a failure-link automaton over bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item with start high; the transfer happens on a clock edge with
//   busy low. Mode pattern adds a byte to the trie, build computes failure
//   links, text walks the automaton, clear empties all tables.
//   Results appear on o_result for one cycle with o_result_valid; there is
//   no backpressure, the receiver must take them.
// Steps from transfer to result strobe:
//   pattern byte: goto read, insert; text byte: goto read, one more per
//   link followed, accept check (not built: end only); build: root scan,
//   then a child scan per queued node, a link walk per child edge, all by
//   single-port sequential goto table reads. Clear and reset sweep the goto
//   table (busy high throughout); items are taken only after it ends.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_core
    import pmbm_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_item i_item,
    output logic     busy,
    output logic     o_result_valid,
    output t_result  o_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    pmbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_item.mode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pmbm_dp #(.MAX_STATES(MAX_STATES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== test/pmbm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pmbm_checker
// Watches the item and result channels of the byte matcher, keeps its own
// copy of the trie, failure links and match state, and compares every result
// transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module pmbm_checker
    import pmbm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_in_item i_item,
    input  logic     i_result_valid,
    input  t_result  i_result,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int NODES = DEF_MAX_STATES;

    logic [7:0] trie_edge [0:NODES*256-1];
    logic [7:0] fail_link [0:NODES-1];
    bit         accepting [0:NODES-1];
    int         node_total;
    int         cur_insert;
    int         cur_match;
    bit         found;
    bit         overflow;
    bit         built;
    t_result    verdict_q[$];

    function automatic int edge_at(int node, int b);
        return trie_edge[node*256 + b];
    endfunction

    function automatic int advance(int node, int b);
        int guard;
        guard = 0;
        while (node != 0 && edge_at(node, b) == 0 && guard < NODES) begin
            node = fail_link[node];
            guard++;
        end
        if (guard >= NODES) node = 0;
        return edge_at(node, b);
    endfunction

    function automatic void clear_all();
        for (int i = 0; i < NODES*256; i++) trie_edge[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            fail_link[i] = '0;
            accepting[i] = 0;
        end
        node_total = 1;
        cur_insert = 0;
        cur_match  = 0;
        found      = 0;
        overflow   = 0;
        built      = 0;
    endfunction

    function automatic void link_trie();
        int order [0:NODES-1];
        int head, tail, t, s, f;
        head = 0;
        tail = 0;
        for (int b = 0; b < 256; b++) begin
            s = edge_at(0, b);
            if (s != 0 && tail < NODES) begin
                fail_link[s] = '0;
                order[tail++] = s;
            end
        end
        while (head < tail) begin
            t = order[head++];
            for (int b = 0; b < 256; b++) begin
                s = edge_at(t, b);
                if (s != 0) begin
                    if (tail < NODES) order[tail++] = s;
                    f = advance(fail_link[t], b);
                    fail_link[s] = f[7:0];
                    if (accepting[f]) accepting[s] = 1;
                end
            end
        end
    endfunction

    function automatic void apply_item(t_in_item it);
        t_result r;
        int s;
        r = '0;
        case (it.mode)
            MODE_PATTERN: begin
                built = 0;
                s = edge_at(cur_insert, it.byte_value);
                if (s == 0) begin
                    if (node_total < NODES) begin
                        s = node_total++;
                        trie_edge[cur_insert*256 + it.byte_value] = s[7:0];
                    end else begin
                        overflow = 1;
                        s = cur_insert;
                    end
                end
                cur_insert = s;
                if (it.last_item) begin
                    if (!overflow) accepting[cur_insert] = 1;
                    cur_insert = 0;
                    r.result_kind = KIND_PATTERN;
                    r.status = overflow ? STATUS_FULL : STATUS_OK;
                    verdict_q = {verdict_q, r};
                end
            end
            MODE_BUILD: begin
                link_trie();
                built = 1;
                cur_match = 0;
                found = 0;
                r.result_kind = KIND_BUILD;
                r.status = overflow ? STATUS_FULL : STATUS_OK;
                verdict_q = {verdict_q, r};
            end
            MODE_TEXT: begin
                if (built) begin
                    cur_match = advance(cur_match, it.byte_value);
                    if (accepting[cur_match]) found = 1;
                end
                if (it.last_item) begin
                    r.result_kind = KIND_TEXT;
                    if (!built) begin
                        r.status = STATUS_NOT_BUILT;
                    end else begin
                        r.status  = overflow ? STATUS_FULL : STATUS_OK;
                        r.matched = found;
                    end
                    cur_match = 0;
                    found = 0;
                    verdict_q = {verdict_q, r};
                end
            end
            default: clear_all();
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            clear_all();
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_result_valid) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = verdict_q.pop_front();
                    if (exp_r !== i_result) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $realtime, exp_r, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) apply_item(i_item);
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pattern, build, text and clear commands into the byte matcher with
// random gaps: a directed opening, a full node table, then random phases of
// small pattern sets with many texts. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
    import pmbm_pkg::*;

    logic     i_clk = 0;
    logic     i_rst_n = 0;
    logic     start = 0;
    t_in_item item = '0;
    logic     busy;
    logic     o_result_valid;
    t_result  o_result;
    int       fail_count;
    int       pending;
    int       sent = 0;
    bit       no_gaps = 0;

    always #4 i_clk = ~i_clk;

    multi_pattern_byte_matcher_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    pmbm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    task automatic send(logic [1:0] mode, logic [7:0] value, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        while (busy) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        item  <= '{mode: mode, byte_value: value, last_item: last};
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    task automatic send_string(logic [1:0] mode, int len);
        for (int i = 0; i < len; i++) send(mode, pick_byte(), i == len - 1);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b1);
        send(MODE_PATTERN, 8'h00, 1'b0);
        send(MODE_PATTERN, 8'hff, 1'b1);
        send(MODE_PATTERN, 8'hff, 1'b1);
        send(MODE_PATTERN, 8'h55, 1'b0);
        send(MODE_PATTERN, 8'haa, 1'b1);
        send(MODE_BUILD, 8'hff, 1'b1);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b1);
        send(MODE_TEXT, 8'h55, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b1);
        send(MODE_TEXT, 8'h12, 1'b0);
        send(MODE_TEXT, 8'h55, 1'b0);
        send(MODE_TEXT, 8'haa, 1'b1);
        send(MODE_TEXT, 8'h55, 1'b0);
        send(MODE_BUILD, 8'h00, 1'b0);
        send(MODE_TEXT, 8'haa, 1'b1);
        send(MODE_PATTERN, 8'h01, 1'b0);
        send(MODE_TEXT, 8'hff, 1'b1);
        send(MODE_BUILD, 8'h00, 1'b0);
        send(MODE_PATTERN, 8'h02, 1'b1);
        send(MODE_CLEAR, 8'hff, 1'b1);
        send(MODE_TEXT, 8'hff, 1'b1);

        // fill the node table, then overflow it
        no_gaps = 1;
        for (int i = 0; i < 255; i++) send(MODE_PATTERN, 8'(i), i == 254);
        no_gaps = 0;
        send(MODE_PATTERN, 8'h01, 1'b0);
        send(MODE_PATTERN, 8'h02, 1'b1);
        send(MODE_BUILD, 8'h00, 1'b0);
        send(MODE_TEXT, 8'h01, 1'b0);
        send(MODE_TEXT, 8'h02, 1'b1);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'h01, 1'b1);
        send(MODE_CLEAR, 8'h00, 1'b0);

        for (int phase = 1; sent < 1200; phase++) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if (phase % 4 == 0) send(MODE_CLEAR, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 5) == 0) send_string(MODE_TEXT, $urandom_range(1, 3));
            repeat ($urandom_range(1, 3)) send_string(MODE_PATTERN, $urandom_range(1, 4));
            send(MODE_BUILD, 8'($urandom), 1'($urandom));
            repeat (12) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send(MODE_TEXT, pick_byte(), 1'b0);
                        send(MODE_BUILD, 8'($urandom), 1'($urandom));
                    end
                    1: begin
                        send_string(MODE_PATTERN, $urandom_range(1, 2));
                        send_string(MODE_TEXT, $urandom_range(1, 3));
                        send(MODE_BUILD, 8'($urandom), 1'($urandom));
                    end
                    default: send_string(MODE_TEXT, $urandom_range(1, 8));
                endcase
            end
        end
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
